### rtl/core/prescaled_pwm_timer_bank_core_assert.svh
// Assertion macros for the prescaled PWM timer bank.
// Used by the port checker; no other dependencies.
`ifndef PRESCALED_PWM_TIMER_BANK_CORE_ASSERT_SVH
`define PRESCALED_PWM_TIMER_BANK_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/ppt_pkg.sv
// Package for the prescaled PWM timer bank: sizes, operation and register codes, payload types.
// No dependencies.
package ppt_pkg;
   localparam int NUM_TIMERS = 5;
   localparam int COUNT_WIDTH = 16;
   localparam int NUM_PWM_OUTPUTS = 4;
   localparam int DATA_WIDTH = 23;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   localparam logic [4:0] REG_PRESCALE = 5'd0;
   localparam logic [4:0] REG_CLKSEL = 5'd1;
   localparam logic [4:0] REG_CONTROL = 5'd2;
   localparam logic [4:0] REG_CNTBUF0 = 5'd3;
   localparam logic [4:0] REG_CMPBUF0 = 5'd8;
   localparam logic [4:0] REG_COUNT0 = 5'd12;

   // Control bit positions per timer.
   localparam int CtlStart[5] = '{0, 8, 12, 16, 20};
   localparam int CtlManual[5] = '{1, 9, 13, 17, 21};
   localparam int CtlInvert[5] = '{2, 10, 14, 18, 0};
   localparam int CtlReload[5] = '{3, 11, 15, 19, 22};

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] reg_index;
      logic [DATA_WIDTH-1:0] write_data;
      logic ext_tick_a;
      logic ext_tick_b;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [NUM_TIMERS-1:0] timer_irq;
      logic [NUM_PWM_OUTPUTS-1:0] pwm_out;
   } rsp_type;
endpackage

### rtl/core/prescaled_pwm_timer_bank_core.sv
// Top level of the prescaled PWM timer bank: register map, prescalers and five timers.
// Depends on ppt_pkg.
//
// Each item (a tick, a register write or a register read) is handled by the combinational logic
// between the timer state and a result register, and one item is accepted every cycle while
// req_ready is high. A second result register lets a new item enter while a finished result
// still waits to be taken, so req_ready drops only when both are full.
module prescaled_pwm_timer_bank_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ppt_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ppt_pkg::rsp_type rsp_data
);
   import ppt_pkg::*;

   logic [7:0] pre_cnt_ff [2];
   logic [7:0] pre_cnt_in [2];
   logic [3:0] div_cnt_ff [2];
   logic [3:0] div_cnt_in [2];
   logic [15:0] pre_set_ff, pre_set_in;
   logic [19:0] clk_sel_ff, clk_sel_in;
   logic [DATA_WIDTH-1:0] ctl_ff, ctl_in;
   logic [COUNT_WIDTH-1:0] cnt_buf_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] cnt_buf_in [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] cmp_buf_ff [NUM_PWM_OUTPUTS];
   logic [COUNT_WIDTH-1:0] cmp_buf_in [NUM_PWM_OUTPUTS];
   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] cnt_in [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] cmp_ff [NUM_PWM_OUTPUTS];
   logic [COUNT_WIDTH-1:0] cmp_in [NUM_PWM_OUTPUTS];

   logic accept;
   logic [1:0] pulse;
   logic [NUM_TIMERS-1:0] irq;
   logic [NUM_PWM_OUTPUTS-1:0] pwm;
   logic [DATA_WIDTH-1:0] rd;
   rsp_type result;

   // Output register plus skid register.
   logic out_vld_ff, skid_vld_ff;
   rsp_type out_ff, skid_ff;

   assign req_ready = !skid_vld_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp_data = out_ff;

   // Next-state logic for one item.
   always_comb begin
      logic [3:0] sel;
      logic clk_t;
      logic grp;
      logic [COUNT_WIDTH-1:0] dec;
      logic [4:0] idx;
      sel = '0;
      clk_t = 1'b0;
      grp = 1'b0;
      dec = '0;
      pre_cnt_in = pre_cnt_ff;
      div_cnt_in = div_cnt_ff;
      pre_set_in = pre_set_ff;
      clk_sel_in = clk_sel_ff;
      ctl_in = ctl_ff;
      cnt_buf_in = cnt_buf_ff;
      cmp_buf_in = cmp_buf_ff;
      cnt_in = cnt_ff;
      cmp_in = cmp_ff;
      irq = '0;
      rd = '0;
      pulse = '0;
      idx = req_data.reg_index;
      unique case (op_type'(req_data.operation))
         OP_TICK: begin
            for (int g = 0; g < 2; g++) begin
               if (pre_cnt_ff[g] >= pre_set_ff[8*g +: 8]) begin
                  pre_cnt_in[g] = '0;
                  pulse[g] = 1'b1;
                  div_cnt_in[g] = div_cnt_ff[g] + 4'd1;
               end else begin
                  pre_cnt_in[g] = pre_cnt_ff[g] + 8'd1;
               end
            end
            for (int t = 0; t < NUM_TIMERS; t++) begin
               grp = (t >= 2);
               sel = clk_sel_ff[4*t +: 4];
               unique case (sel)
                  4'd0: clk_t = pulse[grp] && (div_cnt_in[grp][0] == 1'b0);
                  4'd1: clk_t = pulse[grp] && (div_cnt_in[grp][1:0] == 2'd0);
                  4'd2: clk_t = pulse[grp] && (div_cnt_in[grp][2:0] == 3'd0);
                  4'd3: clk_t = pulse[grp] && (div_cnt_in[grp] == 4'd0);
                  default: clk_t = grp ? req_data.ext_tick_b : req_data.ext_tick_a;
               endcase
               dec = cnt_ff[t] - 1'b1;
               if (ctl_ff[CtlManual[t]]) begin
                  cnt_in[t] = cnt_buf_ff[t];
                  if (t < NUM_PWM_OUTPUTS) cmp_in[t] = cmp_buf_ff[t];
               end else if (ctl_ff[CtlStart[t]] && clk_t) begin
                  if (cnt_ff[t] == '0 || dec == '0) begin
                     if (cnt_ff[t] != '0) irq[t] = 1'b1;
                     if (ctl_ff[CtlReload[t]]) begin
                        cnt_in[t] = cnt_buf_ff[t];
                        if (t < NUM_PWM_OUTPUTS) cmp_in[t] = cmp_buf_ff[t];
                     end else begin
                        cnt_in[t] = '0;
                     end
                  end else begin
                     cnt_in[t] = dec;
                  end
               end
            end
         end
         OP_WRITE: begin
            if (idx == REG_PRESCALE) pre_set_in = req_data.write_data[15:0];
            else if (idx == REG_CLKSEL) clk_sel_in = req_data.write_data[19:0];
            else if (idx == REG_CONTROL) begin
               ctl_in = req_data.write_data;
               for (int t = 0; t < NUM_TIMERS; t++) begin
                  if (req_data.write_data[CtlManual[t]]) begin
                     cnt_in[t] = cnt_buf_ff[t];
                     if (t < NUM_PWM_OUTPUTS) cmp_in[t] = cmp_buf_ff[t];
                  end
               end
            end
            for (int t = 0; t < NUM_TIMERS; t++)
               if (idx == REG_CNTBUF0 + 5'(t)) cnt_buf_in[t] = req_data.write_data[15:0];
            for (int t = 0; t < NUM_PWM_OUTPUTS; t++)
               if (idx == REG_CMPBUF0 + 5'(t)) cmp_buf_in[t] = req_data.write_data[15:0];
         end
         OP_READ: begin
            if (idx == REG_PRESCALE) rd = DATA_WIDTH'(pre_set_ff);
            else if (idx == REG_CLKSEL) rd = DATA_WIDTH'(clk_sel_ff);
            else if (idx == REG_CONTROL) rd = ctl_ff;
            for (int t = 0; t < NUM_TIMERS; t++) begin
               if (idx == REG_CNTBUF0 + 5'(t)) rd = DATA_WIDTH'(cnt_buf_ff[t]);
               if (idx == REG_COUNT0 + 5'(t)) rd = DATA_WIDTH'(cnt_ff[t]);
            end
            for (int t = 0; t < NUM_PWM_OUTPUTS; t++)
               if (idx == REG_CMPBUF0 + 5'(t)) rd = DATA_WIDTH'(cmp_buf_ff[t]);
         end
         default: ;
      endcase
      // PWM levels from the state after this item.
      for (int t = 0; t < NUM_PWM_OUTPUTS; t++)
         pwm[t] = (cnt_in[t] <= cmp_in[t]) ^ ctl_in[CtlInvert[t]];
      result.read_data = rd;
      result.timer_irq = irq;
      result.pwm_out = pwm;
   end

   // Timer state, updated on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_cnt_ff <= '{default: '0};
         div_cnt_ff <= '{default: '0};
         pre_set_ff <= '0;
         clk_sel_ff <= '0;
         ctl_ff <= '0;
         cnt_buf_ff <= '{default: '0};
         cmp_buf_ff <= '{default: '0};
         cnt_ff <= '{default: '0};
         cmp_ff <= '{default: '0};
      end else if (accept) begin
         pre_cnt_ff <= pre_cnt_in;
         div_cnt_ff <= div_cnt_in;
         pre_set_ff <= pre_set_in;
         clk_sel_ff <= clk_sel_in;
         ctl_ff <= ctl_in;
         cnt_buf_ff <= cnt_buf_in;
         cmp_buf_ff <= cmp_buf_in;
         cnt_ff <= cnt_in;
         cmp_ff <= cmp_in;
      end
   end

   // Result register with skid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_ready) begin
            out_vld_ff <= skid_vld_ff || accept;
            skid_vld_ff <= 1'b0;
         end else if (accept) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_ready) begin
         out_ff <= skid_vld_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end
endmodule

### rtl/core/ppt_checker.sv
// Port checker for the prescaled PWM timer bank, bound to the top level.
// Depends on ppt_pkg and the assertion macro header.
`include "prescaled_pwm_timer_bank_core_assert.svh"

module ppt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input ppt_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input ppt_pkg::rsp_type rsp_data
);
   import ppt_pkg::*;

   logic req_accept;
   logic rsp_stall;
   logic read_accept;

   // Handshake terms used by the assertions.
   assign req_accept = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign read_accept = req_accept && rsp_ready && req_data.operation == OP_READ;

   // A stalled result holds.
   `PPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   // After every accepted item, rsp_valid is high in the next cycle.
   `PPT_ASSERT_NEXT(a_rsp_follows, clock, reset, req_accept, rsp_valid)
   // Interrupts only on ticks, so a read result carries none.
   `PPT_ASSERT_NEXT(a_no_irq_on_read, clock, reset, read_accept, rsp_data.timer_irq == '0)
   // The input side is never blocked while the result side is empty.
   `PPT_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
endmodule

bind prescaled_pwm_timer_bank_core ppt_checker u_ppt_checker (.*);

### bench/prescaled_pwm_timer_bank_core_checker.sv
// Checker for the prescaled PWM timer bank: watches both channels and predicts every result.
// Depends on ppt_pkg; instantiated by prescaled_pwm_timer_bank_core_test.
`timescale 1ns / 1ps

module prescaled_pwm_timer_bank_core_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  ppt_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  ppt_pkg::rsp_type rsp_data,
   output int   error_count,
   output int   pending_count
);
   import ppt_pkg::*;

   // Predicted timer state.
   logic [7:0]  pre_cnt [2];
   logic [3:0]  div_cnt [2];
   logic [15:0] pre_set;
   logic [19:0] clk_sel;
   logic [22:0] ctl;
   logic [15:0] cnt_buf [5];
   logic [15:0] cmp_buf [4];
   logic [15:0] down [5];
   logic [15:0] cmp_lat [4];

   rsp_type expected_rsps[$];

   task automatic load_timer(input int t);
      down[t] = cnt_buf[t];
      if (t < 4) cmp_lat[t] = cmp_buf[t];
   endtask

   function automatic logic [3:0] pwm_levels();
      logic [3:0] lv;
      lv = '0;
      for (int t = 0; t < 4; t++)
         lv[t] = (down[t] <= cmp_lat[t]) ^ ctl[CtlInvert[t]];
      return lv;
   endfunction

   // Advance the model by one tick and return the interrupt bits.
   task automatic tick_timers(input logic ea, input logic eb, output logic [4:0] irq);
      logic       pulse [2];
      logic [7:0] setting;
      logic [3:0] sel;
      logic       tclk;
      int         g;
      irq = '0;
      for (int i = 0; i < 2; i++) begin
         setting = pre_set[8*i +: 8];
         if (pre_cnt[i] >= setting) begin
            pre_cnt[i] = '0;
            pulse[i] = 1'b1;
            div_cnt[i] = div_cnt[i] + 4'd1;
         end else begin
            pre_cnt[i] = pre_cnt[i] + 8'd1;
            pulse[i] = 1'b0;
         end
      end
      for (int t = 0; t < 5; t++) begin
         g = (t < 2) ? 0 : 1;
         sel = clk_sel[4*t +: 4];
         if (sel >= 4) tclk = (g == 0) ? ea : eb;
         else tclk = pulse[g] && ((div_cnt[g] & ((5'd2 << sel) - 5'd1)) == 5'd0);
         if (ctl[CtlManual[t]]) begin
            load_timer(t);
         end else if (ctl[CtlStart[t]] && tclk) begin
            if (down[t] == 16'd0) begin
               if (ctl[CtlReload[t]]) load_timer(t);
            end else begin
               down[t] = down[t] - 16'd1;
               if (down[t] == 16'd0) begin
                  irq[t] = 1'b1;
                  if (ctl[CtlReload[t]]) load_timer(t);
               end
            end
         end
      end
   endtask

   task automatic predict_item(input req_type rq);
      rsp_type r;
      logic [4:0] irq;
      logic [4:0] ix;
      r = '0;
      ix = rq.reg_index;
      case (op_type'(rq.operation))
         OP_TICK: begin
            tick_timers(rq.ext_tick_a, rq.ext_tick_b, irq);
            r.timer_irq = irq;
         end
         OP_WRITE: begin
            if (ix == REG_PRESCALE) pre_set = rq.write_data[15:0];
            else if (ix == REG_CLKSEL) clk_sel = rq.write_data[19:0];
            else if (ix == REG_CONTROL) begin
               ctl = rq.write_data;
               for (int t = 0; t < 5; t++) if (ctl[CtlManual[t]]) load_timer(t);
            end else if (ix >= REG_CNTBUF0 && ix < REG_CNTBUF0 + 5)
               cnt_buf[ix - REG_CNTBUF0] = rq.write_data[15:0];
            else if (ix >= REG_CMPBUF0 && ix < REG_CMPBUF0 + 4)
               cmp_buf[ix - REG_CMPBUF0] = rq.write_data[15:0];
         end
         OP_READ: begin
            if (ix == REG_PRESCALE) r.read_data = 23'(pre_set);
            else if (ix == REG_CLKSEL) r.read_data = 23'(clk_sel);
            else if (ix == REG_CONTROL) r.read_data = ctl;
            else if (ix >= REG_CNTBUF0 && ix < REG_CNTBUF0 + 5)
               r.read_data = 23'(cnt_buf[ix - REG_CNTBUF0]);
            else if (ix >= REG_CMPBUF0 && ix < REG_CMPBUF0 + 4)
               r.read_data = 23'(cmp_buf[ix - REG_CMPBUF0]);
            else if (ix >= REG_COUNT0 && ix < REG_COUNT0 + 5)
               r.read_data = 23'(down[ix - REG_COUNT0]);
         end
         default: ;
      endcase
      r.pwm_out = pwm_levels();
      expected_rsps.push_back(r);
   endtask

   assign pending_count = expected_rsps.size();

   // Predict on each accepted input item, compare on each accepted result.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            pre_cnt[i] = 0;
            div_cnt[i] = 0;
         end
         pre_set = 0;
         clk_sel = 0;
         ctl = 0;
         for (int i = 0; i < 5; i++) begin
            cnt_buf[i] = 0;
            down[i] = 0;
         end
         for (int i = 0; i < 4; i++) begin
            cmp_buf[i] = 0;
            cmp_lat[i] = 0;
         end
         expected_rsps.delete();
         error_count = 0;
      end else begin
         if (req_valid && req_ready) predict_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h", $time,
                           want.read_data, rsp_data.read_data);
                  error_count++;
               end
               if (rsp_data.timer_irq !== want.timer_irq) begin
                  $display("%0t: timer_irq expected %h actual %h", $time,
                           want.timer_irq, rsp_data.timer_irq);
                  error_count++;
               end
               if (rsp_data.pwm_out !== want.pwm_out) begin
                  $display("%0t: pwm_out expected %h actual %h", $time,
                           want.pwm_out, rsp_data.pwm_out);
                  error_count++;
               end
            end
         end
      end
   end
endmodule

### bench/prescaled_pwm_timer_bank_core_test.sv
// Top of the timer bank testbench: clock, reset, stimulus, stall pattern and verdict.
// Depends on ppt_pkg, prescaled_pwm_timer_bank_core and its checker.
`timescale 1ns / 1ps

module prescaled_pwm_timer_bank_core_test;
   import ppt_pkg::*;

   localparam int StallLimit = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      idle_cycles;
   bit      quiet_phase;

   prescaled_pwm_timer_bank_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   prescaled_pwm_timer_bank_core_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Send one item; valid stays high until it is accepted.
   task automatic send_item(input op_type op, input logic [4:0] ix,
                            input logic [22:0] wd, input logic ea, input logic eb);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{operation: op, reg_index: ix, write_data: wd,
                    ext_tick_a: ea, ext_tick_b: eb};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [4:0] ix, input logic [22:0] wd);
      send_item(OP_WRITE, ix, wd, 0, 0);
   endtask

   task automatic tick_run(input int n, input bit rand_ext);
      for (int i = 0; i < n; i++)
         send_item(OP_TICK, 5'($urandom_range(0, 31)), 23'($urandom),
                   rand_ext ? 1'($urandom) : 1'b0, rand_ext ? 1'($urandom) : 1'b0);
   endtask

   // Set up a random timer configuration, then run ticks with reads, writes and no-op items mixed in.
   task automatic random_phase(input int n);
      int r;
      write_reg(REG_PRESCALE, 23'($urandom_range(0, 3) | ($urandom_range(0, 3) << 8)));
      write_reg(REG_CLKSEL, 23'($urandom));
      for (int t = 0; t < 5; t++) write_reg(REG_CNTBUF0 + 5'(t), 23'($urandom_range(0, 12)));
      for (int t = 0; t < 4; t++) write_reg(REG_CMPBUF0 + 5'(t), 23'($urandom_range(0, 8)));
      write_reg(REG_CONTROL, 23'($urandom) | 23'h3 | (23'h3 << 8) | (23'h3 << 12)
                | (23'h3 << 16) | (23'h3 << 20));
      write_reg(REG_CONTROL, 23'($urandom) & ~23'h222222 | 23'h111111);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 14)
            send_item(OP_TICK, 5'($urandom), 23'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 17)
            send_item(OP_READ, 5'($urandom_range(0, 31)), 23'($urandom), 0, 0);
         else if (r < 19)
            send_item(OP_WRITE, 5'($urandom_range(0, 31)), 23'($urandom), 0, 0);
         else
            send_item(OP_NONE, 5'($urandom), 23'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   // Receiver stalls in bursts until the quiet phase.
   always @(negedge clock) begin
      if (reset || quiet_phase) rsp_ready <= 1;
      else if (rsp_ready && $urandom_range(0, 7) == 0) rsp_ready <= 0;
      else if (!rsp_ready && $urandom_range(0, 3) == 0) rsp_ready <= 1;
   end

   // Watchdog on cycles without any accepted item or result.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (req_valid || pending_count > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      quiet_phase = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: register extremes, readback, writes, reads and a no-op item.
      write_reg(REG_PRESCALE, 23'h7FFFFF);
      write_reg(REG_CLKSEL, 23'h7FFFFF);
      write_reg(REG_CNTBUF0, 23'h7FFFFF);
      write_reg(REG_CMPBUF0 + 5'd3, 23'h7FFFFF);
      write_reg(5'd12, 23'h1234);
      for (int i = 0; i < 4; i++) send_item(OP_READ, 5'(i), 0, 0, 0);
      send_item(OP_READ, 5'd31, 0, 0, 0);
      send_item(OP_READ, 5'd16, 0, 0, 0);
      send_item(OP_NONE, 5'd31, 23'h7FFFFF, 1, 1);
      // Manual update loads, then external ticks count down through zero.
      write_reg(REG_PRESCALE, 0);
      write_reg(REG_CNTBUF0 + 5'd4, 2);
      write_reg(REG_CONTROL, 23'h7FFFFF);
      write_reg(REG_CONTROL, 23'h111111);
      tick_run(4, 1);
      send_item(OP_TICK, 0, 0, 1, 1);
      // Auto-reload, divided clocks, and lowering the prescaler below its count.
      write_reg(REG_CLKSEL, 23'h03210);
      write_reg(REG_PRESCALE, 23'hFFFF);
      tick_run(3, 0);
      write_reg(REG_PRESCALE, 23'h0101);
      write_reg(REG_CONTROL, 23'h5DDDD9);
      tick_run(2, 0);

      for (int ph = 0; ph < 16; ph++) begin
         if (ph == 14) quiet_phase = 1;
         random_phase(90);
         // Idle between phases until every result is in.
         req_valid <= 0;
         while (pending_count > 0) @(negedge clock);
         repeat (3) @(negedge clock);
      end

      req_valid <= 0;
      while (pending_count > 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ppt_pkg.sv
rtl/core/prescaled_pwm_timer_bank_core.sv
rtl/core/ppt_checker.sv
bench/prescaled_pwm_timer_bank_core_checker.sv
bench/prescaled_pwm_timer_bank_core_test.sv
